>>> hw/rtl/btlpm_pkg.sv
package btlpm_pkg;

    // Trie node pool and address walk
    localparam int NODE_COUNT   = 1024;
    localparam int ADDRESS_BITS = 32;
    localparam int NODE_W       = $clog2(NODE_COUNT);
    localparam int FREE_W       = NODE_W + 1;
    localparam int LEVEL_W      = $clog2(ADDRESS_BITS + 1);

    // Field widths on the ports
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int TDATA_W = ((ADDR_W + LEN_W + 7) / 8) * 8;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [ADDRESS_BITS-1:0]  addr;
        logic [LEVEL_W-1:0]       len;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic              valid;
    } node_t;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] prefix;
        logic [LEVEL_W-1:0]      len;
    } route_t;

endpackage

>>> hw/rtl/btlpm_front.sv
module btlpm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [btlpm_pkg::TDATA_W-1:0] s_tdata,   // address, prefix_length
    input  logic                          s_tuser,   // operation
    output logic                          q_valid,
    input  logic                          q_ready,
    output btlpm_pkg::item_t              q_item
);

    btlpm_pkg::item_t                  slot_reg [btlpm_pkg::QDEPTH];
    logic [btlpm_pkg::QPTR_W-1:0]      head_reg, head_next;
    logic [btlpm_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic [btlpm_pkg::QPTR_W-1:0]      tail;
    logic [btlpm_pkg::LEN_W-1:0]       len_in;
    btlpm_pkg::item_t                  item_in;
    logic                              push, pop;

    // classify: pass the address through, clamp the length to the walk depth
    always_comb begin
        len_in       = s_tdata[btlpm_pkg::ADDR_W+btlpm_pkg::LEN_W-1:btlpm_pkg::ADDR_W];
        item_in.op   = btlpm_pkg::op_t'(s_tuser);
        item_in.addr = s_tdata[btlpm_pkg::ADDRESS_BITS-1:0];
        if (len_in > btlpm_pkg::LEN_W'(btlpm_pkg::ADDRESS_BITS)) begin
            item_in.len = btlpm_pkg::LEVEL_W'(btlpm_pkg::ADDRESS_BITS);
        end else begin
            item_in.len = btlpm_pkg::LEVEL_W'(len_in);
        end
    end

    assign s_tready = (count_reg != btlpm_pkg::QCNT_W'(btlpm_pkg::QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[head_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;
    assign tail     = head_reg + btlpm_pkg::QPTR_W'(count_reg);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (pop) begin
            head_next = head_reg + btlpm_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + btlpm_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - btlpm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[tail] <= item_in;
        end
    end

endmodule

>>> hw/rtl/btlpm_back.sv
module btlpm_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  btlpm_pkg::item_t              q_item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [btlpm_pkg::TDATA_W-1:0] m_tdata,   // matched_prefix, matched_length
    output logic [1:0]                    m_tuser    // hit, pool_full
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_ALLOC,
        ST_ROUTE
    } state_t;

    localparam int NW = btlpm_pkg::NODE_W;
    localparam int AB = btlpm_pkg::ADDRESS_BITS;
    localparam int LW = btlpm_pkg::LEVEL_W;

    // node pool and route store
    btlpm_pkg::node_t  node_mem  [btlpm_pkg::NODE_COUNT];
    btlpm_pkg::route_t route_mem [btlpm_pkg::NODE_COUNT];
    btlpm_pkg::node_t  node_rd_reg;
    btlpm_pkg::route_t route_rd_reg;

    logic              node_we;
    logic [NW-1:0]     node_wr_addr, node_rd_addr;
    btlpm_pkg::node_t  node_wr_data;
    logic              route_we;
    logic [NW-1:0]     route_wr_addr, route_rd_addr;
    btlpm_pkg::route_t route_wr_data;

    state_t                        state_reg, state_next;
    btlpm_pkg::op_t                op_reg, op_next;
    logic [LW-1:0]                 len_reg, len_next;
    logic [LW-1:0]                 level_reg, level_next;
    logic [AB-1:0]                 addr_reg, addr_next;
    logic [AB-1:0]                 shift_reg, shift_next;
    logic [NW-1:0]                 node_reg, node_next;
    logic [NW-1:0]                 best_reg, best_next;
    logic                          found_reg, found_next;
    logic                          fresh_reg, fresh_next;
    logic [btlpm_pkg::FREE_W-1:0]  free_reg, free_next;

    logic                          m_valid_reg, m_valid_next;
    logic                          hit_reg, hit_next;
    logic                          full_reg, full_next;
    logic [btlpm_pkg::ADDR_W-1:0]  prefix_reg, prefix_next;
    logic [btlpm_pkg::LEN_W-1:0]   length_reg, length_next;

    btlpm_pkg::node_t rec;
    logic             cur_bit;
    logic [NW-1:0]    child;
    logic             found_here;
    logic [NW-1:0]    best_here;
    logic             out_free;
    logic             pool_out;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = btlpm_pkg::TDATA_W'({length_reg, prefix_reg});
    assign m_tuser  = {full_reg, hit_reg};
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        // a node allocated in the previous step is known empty
        rec        = fresh_reg ? '0 : node_rd_reg;
        cur_bit    = shift_reg[AB-1];
        child      = cur_bit ? rec.right : rec.left;
        found_here = found_reg || rec.valid;
        best_here  = rec.valid ? node_reg : best_reg;
        pool_out   = (free_reg == btlpm_pkg::FREE_W'(btlpm_pkg::NODE_COUNT));

        state_next   = state_reg;
        op_next      = op_reg;
        len_next     = len_reg;
        level_next   = level_reg;
        addr_next    = addr_reg;
        shift_next   = shift_reg;
        node_next    = node_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        fresh_next   = fresh_reg;
        free_next    = free_reg;
        m_valid_next = m_valid_reg && !m_tready;
        hit_next     = hit_reg;
        full_next    = full_reg;
        prefix_next  = prefix_reg;
        length_next  = length_reg;

        q_ready       = 1'b0;
        node_rd_addr  = child;
        node_we       = 1'b0;
        node_wr_addr  = node_reg;
        node_wr_data  = rec;
        route_we      = 1'b0;
        route_wr_addr = node_reg;
        route_wr_data = '{prefix: addr_reg, len: len_reg};
        route_rd_addr = best_here;

        unique case (state_reg)
            ST_CLEAR: begin
                node_we      = 1'b1;
                node_wr_addr = '0;
                node_wr_data = '0;
                state_next   = ST_IDLE;
            end
            ST_IDLE: begin
                node_rd_addr = '0;
                q_ready      = out_free;
                if (q_valid && out_free) begin
                    op_next    = q_item.op;
                    len_next   = q_item.len;
                    addr_next  = q_item.addr;
                    shift_next = q_item.addr;
                    level_next = '0;
                    node_next  = '0;
                    best_next  = '0;
                    found_next = 1'b0;
                    fresh_next = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (op_reg == btlpm_pkg::OP_LOOKUP) begin
                    if (level_reg == LW'(AB) || child == '0) begin
                        if (found_here) begin
                            best_next  = best_here;
                            state_next = ST_ROUTE;
                        end else begin
                            m_valid_next = 1'b1;
                            hit_next     = 1'b0;
                            full_next    = 1'b0;
                            prefix_next  = '0;
                            length_next  = '0;
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        node_next  = child;
                        level_next = level_reg + LW'(1);
                        shift_next = shift_reg << 1;
                        found_next = found_here;
                        best_next  = best_here;
                        fresh_next = 1'b0;
                    end
                end else begin
                    if (level_reg == len_reg) begin
                        // mark the route, overwriting any earlier entry
                        node_we            = 1'b1;
                        node_wr_data.valid = 1'b1;
                        route_we           = 1'b1;
                        m_valid_next       = 1'b1;
                        hit_next           = 1'b1;
                        full_next          = 1'b0;
                        prefix_next        = '0;
                        length_next        = '0;
                        state_next         = ST_IDLE;
                    end else if (child != '0) begin
                        node_next  = child;
                        level_next = level_reg + LW'(1);
                        shift_next = shift_reg << 1;
                        fresh_next = 1'b0;
                    end else if (pool_out) begin
                        m_valid_next = 1'b1;
                        hit_next     = 1'b0;
                        full_next    = 1'b1;
                        prefix_next  = '0;
                        length_next  = '0;
                        state_next   = ST_IDLE;
                    end else begin
                        // link a new child into the parent, clear it next cycle
                        node_we = 1'b1;
                        if (cur_bit) begin
                            node_wr_data.right = free_reg[NW-1:0];
                        end else begin
                            node_wr_data.left = free_reg[NW-1:0];
                        end
                        node_next  = free_reg[NW-1:0];
                        free_next  = free_reg + btlpm_pkg::FREE_W'(1);
                        level_next = level_reg + LW'(1);
                        shift_next = shift_reg << 1;
                        state_next = ST_ALLOC;
                    end
                end
            end
            ST_ALLOC: begin
                node_we      = 1'b1;
                node_wr_data = '0;
                fresh_next   = 1'b1;
                state_next   = ST_WALK;
            end
            ST_ROUTE: begin
                m_valid_next = 1'b1;
                hit_next     = 1'b1;
                full_next    = 1'b0;
                prefix_next  = btlpm_pkg::ADDR_W'(route_rd_reg.prefix);
                length_next  = btlpm_pkg::LEN_W'(route_rd_reg.len);
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            free_reg    <= btlpm_pkg::FREE_W'(1);
            m_valid_reg <= 1'b0;
            fresh_reg   <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
            fresh_reg   <= fresh_next;
            found_reg   <= found_next;
        end
        op_reg     <= op_next;
        len_reg    <= len_next;
        level_reg  <= level_next;
        addr_reg   <= addr_next;
        shift_reg  <= shift_next;
        node_reg   <= node_next;
        best_reg   <= best_next;
        hit_reg    <= hit_next;
        full_reg   <= full_next;
        prefix_reg <= prefix_next;
        length_reg <= length_next;
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_wr_addr] <= node_wr_data;
        end
        node_rd_reg <= node_mem[node_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (route_we) begin
            route_mem[route_wr_addr] <= route_wr_data;
        end
        route_rd_reg <= route_mem[route_rd_addr];
    end

`ifndef SYNTHESIS
    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg != '0 && free_reg <= btlpm_pkg::FREE_W'(btlpm_pkg::NODE_COUNT))
        else $error("free node counter out of range");

    a_hit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(hit_reg && full_reg))
        else $error("result flags both hit and pool_full");

    a_walk_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> level_reg <= LW'(AB))
        else $error("walk went past the address width");

    a_alloc_then_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ALLOC |=> state_reg == ST_WALK && fresh_reg)
        else $error("new node not cleared before walk resumed");
`endif

endmodule

>>> hw/rtl/binary_trie_longest_prefix_match.sv
// Path: a lookup passes the queue, the root read, one node read per level, the route read
//   on a hit and the output register on its way to the result beat; a miss skips the route read.
//   An insert walks to its length; each node it allocates is linked, then cleared.
// Throughput: one item at a time in the walk engine, which takes no new item before its
//   result; the engine waits while a result beat is held off, the two-beat queue does not.
// Reset: synchronous, active low; the cycle after reset clears the root node entry.
module binary_trie_longest_prefix_match (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [btlpm_pkg::TDATA_W-1:0] s_tdata,   // [31:0] address, [37:32] prefix_length
    input  logic                          s_tuser,   // [0] operation (0 insert, 1 lookup)
    // result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [btlpm_pkg::TDATA_W-1:0] m_tdata,   // [31:0] matched_prefix, [37:32] matched_length
    output logic [1:0]                    m_tuser    // [0] hit, [1] pool_full
);

    // front -> back queue head
    logic             q_valid;
    logic             q_ready;
    btlpm_pkg::item_t q_item;

    // Front: takes beats, passes the address through and clamps the length, holds up to two items.
    btlpm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // Back: walks the trie one level per node read, allocates nodes on insert,
    // tracks the deepest marked node on lookup and registers the result beat.
    btlpm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
